[src/clir_pkg.sv]
// Package for the circular list block: payload structs, codes and fixed widths.
`default_nettype none

package clir_pkg;

  // Fixed field widths of the payload.
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OFFS_W   = 16;
  localparam int unsigned ECOUNT_W = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned STEP_W   = $clog2(OFFS_W);

  // Operation codes of an input transaction.
  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_VISIT  = 1'b1
  } op_e;

  // Status codes of a result transaction.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ROTATE = 2'd2
  } cell_cmd_e;

  typedef struct packed {
    op_e                      opcode;
    logic signed [OFFS_W-1:0] position;
    logic signed [WORD_W-1:0] value;
    logic signed [OFFS_W-1:0] distance;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] current_value;
    logic [ECOUNT_W-1:0]      element_count;
    status_e                  status;
  } out_t;

endpackage

`default_nettype wire

[src/clir_cell.sv]
// One storage cell of the ring: holds a word and trades it with its neighbours.
`default_nettype none

module clir_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CNT_W    = 5
) (
  input  wire                               clk_i,
  input  clir_pkg::cell_cmd_e               cmd_i,
  input  wire [IDX_W-1:0]                   slot_i,
  input  wire [CNT_W-1:0]                   count_i,
  input  wire [IDX_W-1:0]                   last_i,
  input  wire [clir_pkg::WORD_W-1:0]        ins_word_i,
  input  wire [clir_pkg::WORD_W-1:0]        left_word_i,
  input  wire [clir_pkg::WORD_W-1:0]        right_word_i,
  input  wire [clir_pkg::WORD_W-1:0]        head_word_i,
  output logic [clir_pkg::WORD_W-1:0]       word_o
);

  localparam logic [IDX_W-1:0] MyIdx  = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MyCIdx = CNT_W'(CELL_IDX);

  logic [clir_pkg::WORD_W-1:0] word_q, word_d;

  // Insert opens a gap at the slot by moving the tail one place up; rotate
  // moves every held word one place down, the head wrapping to the last one.
  always_comb begin
    word_d = word_q;
    case (cmd_i)
      clir_pkg::CMD_INSERT: begin
        if (MyIdx == slot_i) begin
          word_d = ins_word_i;
        end else if ((MyIdx > slot_i) && (MyCIdx <= count_i)) begin
          word_d = left_word_i;
        end
      end
      clir_pkg::CMD_ROTATE: begin
        if (MyIdx < last_i) begin
          word_d = right_word_i;
        end else if (MyIdx == last_i) begin
          word_d = head_word_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

[src/clir_modulo.sv]
// Bit-serial floor modulo of a 16-bit magnitude by the element count.
`default_nettype none

module clir_modulo #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [clir_pkg::OFFS_W-1:0]   dividend_i,
  input  wire [CNT_W-1:0]              divisor_i,
  input  wire                          negate_i,
  output logic                         done_o,
  output logic [IDX_W-1:0]             rem_o
);

  localparam int unsigned DW = clir_pkg::OFFS_W;
  localparam int unsigned SW = clir_pkg::STEP_W;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SW-1:0]     step_q, step_d;
  logic [DW-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic              neg_q, neg_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W-1:0]  rem_next;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_next = CNT_W'(trial - {1'b0, div_q});
    end else begin
      rem_next = CNT_W'(trial);
    end
  end

  // Sequencing of the sixteen steps; the last step folds a negative
  // dividend back into the range from zero to the divisor.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      neg_d  = negate_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[DW-2:0], 1'b0};
      rem_d  = rem_next;
      step_d = step_q + SW'(1);
      if (step_q == SW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (neg_q && (rem_next != '0)) begin
          rem_d = div_q - rem_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign rem_o  = IDX_W'(rem_q);

endmodule

`default_nettype wire

[src/circular_list_insert_and_rotate.sv]
// Top level of the circular list with insert and rotate.
`default_nettype none

// Usage: input transactions (insert or visit) arrive on in_valid_i/in_data_i
// and are taken at an edge where in_valid_i is high and in_stall_o is low.
// Each one yields exactly one result transaction on out_valid_o/out_data_o,
// taken when out_valid_o is high and out_stall_i is low.
// The list is a chain of CAPACITY cells with the current element in cell 0.
// Path from acceptance to the result being offered:
//   insert into an empty list or at position zero or below: insert, then result;
//   insert into a full list, or visit on an empty list: straight to the result;
//   insert at a positive position: serial modulo, insert, then result;
//   visit: serial modulo, then the rotation steps, the step count being
//   the distance taken modulo the element count (at most count - 1).
// One transaction is in work at a time; the serial modulo unit works bit by bit
// and the cell chain rotates one place per cycle.
// A finished result sits in the output register, and a new transaction is
// accepted while it waits; that one completes once the register is free.
// Reset empties the list (count zero), returns the sequencer to idle and clears the output valid flag.

module circular_list_insert_and_rotate #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  clir_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output clir_pkg::out_t      out_data_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned WW    = clir_pkg::WORD_W;
  localparam int unsigned OW    = clir_pkg::OFFS_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOD    = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_ROT    = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  clir_pkg::op_e           op_q, op_d;
  clir_pkg::status_e       status_q, status_d;
  logic [WW-1:0]           word_q, word_d;
  logic [IDX_W-1:0]        slot_q, slot_d;
  logic [IDX_W-1:0]        rot_q, rot_d;
  logic                    out_valid_q, out_valid_d;
  clir_pkg::out_t          out_q, out_d;

  logic                    accept;
  logic                    mod_start;
  logic [OW-1:0]           mod_dividend;
  logic                    mod_negate;
  logic                    mod_done;
  logic [IDX_W-1:0]        mod_rem;
  clir_pkg::cell_cmd_e     cell_cmd;
  logic [IDX_W-1:0]        last_idx;
  logic [WW-1:0]           cell_word [CAPACITY];
  logic [31:0]             count_ext;
  logic                    out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_idx = IDX_W'(count_q - CNT_W'(1));

  // Sequencer: decides the slot or rotation, drives the cells, posts the result.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    op_d         = op_q;
    status_d     = status_q;
    word_d       = word_q;
    slot_d       = slot_q;
    rot_d        = rot_q;
    mod_start    = 1'b0;
    mod_dividend = '0;
    mod_negate   = 1'b0;
    cell_cmd     = clir_pkg::CMD_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = in_data_i.opcode;
          word_d   = in_data_i.value;
          status_d = clir_pkg::STAT_OK;
          slot_d   = '0;
          if (in_data_i.opcode == clir_pkg::OP_INSERT) begin
            if (count_q >= CNT_W'(CAPACITY)) begin
              status_d = clir_pkg::STAT_FULL;
              state_d  = S_RESULT;
            end else if ((count_q == '0) || (in_data_i.position == '0)) begin
              slot_d  = '0;
              state_d = S_APPLY;
            end else if (in_data_i.position[OW-1]) begin
              slot_d  = IDX_W'(1);
              state_d = S_APPLY;
            end else begin
              mod_start    = 1'b1;
              mod_dividend = in_data_i.position - OW'(1);
              state_d      = S_MOD;
            end
          end else begin
            if (count_q == '0) begin
              status_d = clir_pkg::STAT_EMPTY;
              state_d  = S_RESULT;
            end else begin
              mod_start    = 1'b1;
              mod_negate   = in_data_i.distance[OW-1];
              mod_dividend = in_data_i.distance[OW-1] ?
                             (~in_data_i.distance + OW'(1)) : in_data_i.distance;
              state_d      = S_MOD;
            end
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          if (op_q == clir_pkg::OP_INSERT) begin
            slot_d  = mod_rem + IDX_W'(1);
            state_d = S_APPLY;
          end else if (mod_rem == '0) begin
            state_d = S_RESULT;
          end else begin
            rot_d   = mod_rem;
            state_d = S_ROT;
          end
        end
      end
      S_APPLY: begin
        cell_cmd = clir_pkg::CMD_INSERT;
        count_d  = count_q + CNT_W'(1);
        state_d  = S_RESULT;
      end
      S_ROT: begin
        cell_cmd = clir_pkg::CMD_ROTATE;
        rot_d    = rot_q - IDX_W'(1);
        if (rot_q == IDX_W'(1)) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: loaded from the cell chain once the sequencer is done.
  assign count_ext = 32'(count_q);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if ((state_q == S_RESULT) && out_free) begin
      out_valid_d         = 1'b1;
      out_d.current_value = (count_q != '0) ? cell_word[0] : '0;
      out_d.element_count = count_ext[clir_pkg::ECOUNT_W-1:0];
      out_d.status        = status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    word_q   <= word_d;
    slot_q   <= slot_d;
    rot_q    <= rot_d;
    out_q    <= out_d;
  end

  // Serial modulo unit shared by insert and visit.
  clir_modulo #(
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_modulo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (count_q),
    .negate_i   (mod_negate),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // The chain of cells; cell 0 holds the current element.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WW-1:0] left_word;
    logic [WW-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = word_q;
    end else begin : g_left
      assign left_word = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_word = cell_word[0];
    end else begin : g_right
      assign right_word = cell_word[i+1];
    end

    clir_cell #(
      .CELL_IDX (i),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cell_cmd),
      .slot_i       (slot_q),
      .count_i      (count_q),
      .last_i       (last_idx),
      .ins_word_i   (word_q),
      .left_word_i  (left_word),
      .right_word_i (right_word),
      .head_word_i  (cell_word[0]),
      .word_o       (cell_word[i])
    );
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
